// ===== rtl/core/mcfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfsm_pkg
// Types, codes and control word table for the multicycle control unit.
// ----------------------------------------------------------------------------
package mcfsm_pkg;

    // one-hot controller states, bit position equals the reported state code
    typedef enum logic [15:0] {
        S_FETCH   = 16'h0001,
        S_DECODE  = 16'h0002,
        S_JUMP    = 16'h0004,
        S_JR      = 16'h0008,
        S_EXEC_R  = 16'h0010,
        S_BRANCH  = 16'h0020,
        S_LWSW    = 16'h0040,
        S_WB_R    = 16'h0080,
        S_SHIFT   = 16'h0100,
        S_SLT     = 16'h0200,
        S_EXEC_I  = 16'h0400,
        S_WB_I    = 16'h0800,
        S_LW_READ = 16'h1000,
        S_SW      = 16'h2000,
        S_WB_LW   = 16'h4000,
        S_JAL     = 16'h8000
    } t_state;

    typedef enum logic [3:0] {
        ALU_ADD = 4'd0,
        ALU_SUB = 4'd1,
        ALU_AND = 4'd2,
        ALU_OR  = 4'd3,
        ALU_NOR = 4'd4,
        ALU_SLT = 4'd5,
        ALU_SLL = 4'd6,
        ALU_SRL = 4'd7,
        ALU_BNE = 4'd8
    } t_alu_op;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_JR  = 6'h08;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_NOR = 6'h27;
    localparam logic [5:0] FN_SLT = 6'h2A;

    localparam logic [1:0] PCU_NONE   = 2'd0;
    localparam logic [1:0] PCU_ALWAYS = 2'd1;
    localparam logic [1:0] PCU_COND   = 2'd2;

    localparam logic [1:0] PCS_ALU    = 2'd0;
    localparam logic [1:0] PCS_ALUOUT = 2'd1;
    localparam logic [1:0] PCS_JUMP   = 2'd2;
    localparam logic [1:0] PCS_REG    = 2'd3;

    localparam logic [1:0] SRCA_PC    = 2'd0;
    localparam logic [1:0] SRCA_REGA  = 2'd1;
    localparam logic [1:0] SRCA_THIRD = 2'd2;

    localparam logic [1:0] SRCB_REGB  = 2'd0;
    localparam logic [1:0] SRCB_FOUR  = 2'd1;
    localparam logic [1:0] SRCB_IMM   = 2'd2;
    localparam logic [1:0] SRCB_SHIMM = 2'd3;

    localparam logic [1:0] DST_RT   = 2'd0;
    localparam logic [1:0] DST_RD   = 2'd1;
    localparam logic [1:0] DST_LINK = 2'd2;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [1:0] WD_ALUOUT = 2'd0;
    localparam logic [1:0] WD_MEM    = 2'd1;
    localparam logic [1:0] WD_PC     = 2'd2;

    typedef struct packed {
        logic [1:0] pc_update;
        logic [1:0] pc_source;
        logic [1:0] alu_src_a;
        logic [1:0] alu_src_b;
        logic       reg_write;
        logic [1:0] reg_dst;
        logic       i_or_d;
        logic [1:0] mem_cmd;
        logic [1:0] reg_data_loc;
        logic       ir_write;
    } t_ctl;

    // next state and ALU operation produced for one step
    typedef struct packed {
        t_state  state;
        t_alu_op alu_op;
    } t_step;

    function automatic logic [3:0] state_code(input t_state st);
        logic [3:0] code;
        code = '0;
        for (int i = 0; i < 16; i++) begin
            if (st[i]) code = 4'(i);
        end
        return code;
    endfunction

    function automatic t_ctl ctl_word(input t_state st);
        t_ctl c;
        c = '0;
        unique case (st)
            S_FETCH: begin
                c.pc_update = PCU_ALWAYS;
                c.alu_src_b = SRCB_FOUR;
                c.mem_cmd   = MEM_READ;
                c.ir_write  = 1'b1;
            end
            S_DECODE: c.alu_src_b = SRCB_SHIMM;
            S_JUMP: begin
                c.pc_update = PCU_ALWAYS;
                c.pc_source = PCS_JUMP;
                c.alu_src_b = SRCB_SHIMM;
            end
            S_JR: begin
                c.pc_update = PCU_ALWAYS;
                c.pc_source = PCS_REG;
            end
            S_EXEC_R: c.alu_src_a = SRCA_REGA;
            S_BRANCH: begin
                c.pc_update = PCU_COND;
                c.pc_source = PCS_ALUOUT;
                c.alu_src_a = SRCA_REGA;
            end
            S_LWSW: begin
                c.alu_src_a = SRCA_REGA;
                c.alu_src_b = SRCB_IMM;
            end
            S_WB_R: begin
                c.alu_src_a = SRCA_THIRD;
                c.reg_write = 1'b1;
                c.reg_dst   = DST_RD;
            end
            S_SHIFT: c.alu_src_a = SRCA_THIRD;
            S_SLT:   c.alu_src_a = SRCA_REGA;
            S_EXEC_I: begin
                c.alu_src_a = SRCA_REGA;
                c.alu_src_b = SRCB_IMM;
            end
            S_WB_I: c.reg_write = 1'b1;
            S_LW_READ: begin
                c.i_or_d  = 1'b1;
                c.mem_cmd = MEM_READ;
            end
            S_SW: begin
                c.i_or_d  = 1'b1;
                c.mem_cmd = MEM_WRITE;
            end
            S_WB_LW: begin
                c.reg_write    = 1'b1;
                c.i_or_d       = 1'b1;
                c.reg_data_loc = WD_MEM;
            end
            S_JAL: begin
                c.pc_update    = PCU_ALWAYS;
                c.pc_source    = PCS_JUMP;
                c.alu_src_b    = SRCB_SHIMM;
                c.reg_write    = 1'b1;
                c.reg_dst      = DST_LINK;
                c.reg_data_loc = WD_PC;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/multicycle_cpu_control_fsm.sv =====
// ----------------------------------------------------------------------------
// multicycle_cpu_control_fsm
// Multicycle processor control unit: one transfer in is one clock step of
// the controller, one transfer out is the control word of the new state.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  input   | i_valid  | o_stall  | i_instruction
//  output  | o_valid  | i_stall  | o_fsm_state .. o_ir_write
//
//  one step per cycle unless o_stall holds it; input register then result register
//  the state update and control word decode sit between those two registers
//  reset puts the controller in fetch with ALU add and both stages empty
//  o_stall is high only while the input register is full and the result
//  register is full and stalled
// ----------------------------------------------------------------------------
module multicycle_cpu_control_fsm
    import mcfsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_fsm_state,
    output logic [1:0]  o_pc_update,
    output logic [1:0]  o_pc_source,
    output logic [3:0]  o_alu_operation,
    output logic [1:0]  o_alu_src_a,
    output logic [1:0]  o_alu_src_b,
    output logic        o_reg_write,
    output logic [1:0]  o_reg_dst,
    output logic        o_i_or_d,
    output logic [1:0]  o_mem_cmd,
    output logic [1:0]  o_reg_data_loc,
    output logic        o_ir_write
);

    logic       r_in_valid, n_in_valid;
    logic [5:0] r_opcode;
    logic [5:0] r_funct;
    t_state     r_state;
    t_alu_op    r_alu_op;
    logic       out_free;
    logic       load;
    logic       in_take;
    t_step      step;

    assign load    = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;
    assign in_take = i_valid && !o_stall;
    assign n_in_valid = in_take || (r_in_valid && !load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= S_FETCH;
            r_alu_op   <= ALU_ADD;
        end else begin
            r_in_valid <= n_in_valid;
            if (load) begin
                r_state  <= step.state;
                r_alu_op <= step.alu_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode <= i_instruction[31:26];
            r_funct  <= i_instruction[5:0];
        end
    end

    mcfsm_next u_next (
        .i_state  (r_state),
        .i_alu_op (r_alu_op),
        .i_opcode (r_opcode),
        .i_funct  (r_funct),
        .o_step   (step)
    );

    mcfsm_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_step          (step),
        .i_stall         (i_stall),
        .o_free          (out_free),
        .o_valid         (o_valid),
        .o_fsm_state     (o_fsm_state),
        .o_pc_update     (o_pc_update),
        .o_pc_source     (o_pc_source),
        .o_alu_operation (o_alu_operation),
        .o_alu_src_a     (o_alu_src_a),
        .o_alu_src_b     (o_alu_src_b),
        .o_reg_write     (o_reg_write),
        .o_reg_dst       (o_reg_dst),
        .o_i_or_d        (o_i_or_d),
        .o_mem_cmd       (o_mem_cmd),
        .o_reg_data_loc  (o_reg_data_loc),
        .o_ir_write      (o_ir_write)
    );

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_fsm_state == state_code(r_state)) && (o_alu_operation == r_alu_op))
        else $error("result word does not match controller state");

    a_fetch_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_state == S_FETCH)) |=> (r_state == S_DECODE))
        else $error("fetch did not advance to decode");

    a_op_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alu_op != ALU_ADD) |-> ((r_state == S_EXEC_R) || (r_state == S_BRANCH) ||
            (r_state == S_SHIFT) || (r_state == S_SLT) || (r_state == S_EXEC_I)))
        else $error("held ALU operation outside an execute state");

    a_state_held_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_state))
        else $error("controller state moved without a transfer");

endmodule

// ===== rtl/core/mcfsm_next.sv =====
// ----------------------------------------------------------------------------
// mcfsm_next
// Next-state and ALU operation logic of the multicycle controller.
// ----------------------------------------------------------------------------
module mcfsm_next
    import mcfsm_pkg::*;
(
    input  t_state     i_state,
    input  t_alu_op    i_alu_op,
    input  logic [5:0] i_opcode,
    input  logic [5:0] i_funct,
    output t_step      o_step
);

    function automatic t_alu_op rtype_op(input logic [5:0] fn);
        t_alu_op op;
        unique case (fn)
            FN_SUB:  op = ALU_SUB;
            FN_AND:  op = ALU_AND;
            FN_OR:   op = ALU_OR;
            FN_NOR:  op = ALU_NOR;
            FN_SLT:  op = ALU_SLT;
            FN_SLL:  op = ALU_SLL;
            FN_SRL:  op = ALU_SRL;
            default: op = ALU_ADD;
        endcase
        return op;
    endfunction

    always_comb begin
        o_step.state  = S_FETCH;
        o_step.alu_op = ALU_ADD;
        unique case (i_state)
            S_FETCH: o_step.state = S_DECODE;
            S_DECODE: begin
                unique case (i_opcode)
                    OP_J:   o_step.state = S_JUMP;
                    OP_JAL: o_step.state = S_JAL;
                    OP_BEQ: begin
                        o_step.state  = S_BRANCH;
                        o_step.alu_op = ALU_SUB;
                    end
                    OP_BNE: begin
                        o_step.state  = S_BRANCH;
                        o_step.alu_op = ALU_BNE;
                    end
                    OP_LW, OP_SW: o_step.state = S_LWSW;
                    OP_ADDI: o_step.state = S_EXEC_I;
                    OP_ANDI: begin
                        o_step.state  = S_EXEC_I;
                        o_step.alu_op = ALU_AND;
                    end
                    OP_ORI: begin
                        o_step.state  = S_EXEC_I;
                        o_step.alu_op = ALU_OR;
                    end
                    OP_RTYPE: begin
                        unique case (i_funct)
                            FN_SLL: begin
                                o_step.state  = S_SHIFT;
                                o_step.alu_op = ALU_SLL;
                            end
                            FN_SRL: begin
                                o_step.state  = S_SHIFT;
                                o_step.alu_op = ALU_SRL;
                            end
                            FN_JR: o_step.state = S_JR;
                            FN_SLT: begin
                                o_step.state  = S_SLT;
                                o_step.alu_op = ALU_SLT;
                            end
                            default: begin
                                o_step.state  = S_EXEC_R;
                                o_step.alu_op = rtype_op(i_funct);
                            end
                        endcase
                    end
                    // unknown opcode holds the controller where it is
                    default: begin
                        o_step.state  = i_state;
                        o_step.alu_op = i_alu_op;
                    end
                endcase
            end
            S_EXEC_R, S_SHIFT, S_SLT: o_step.state = S_WB_R;
            S_EXEC_I:  o_step.state = S_WB_I;
            S_LWSW:    o_step.state = (i_opcode == OP_LW) ? S_LW_READ : S_SW;
            S_LW_READ: o_step.state = S_WB_LW;
            default:   o_step.state = S_FETCH;
        endcase
    end

endmodule

// ===== rtl/core/mcfsm_out.sv =====
// ----------------------------------------------------------------------------
// mcfsm_out
// Result register holding the new state's control word.
// ----------------------------------------------------------------------------
module mcfsm_out
    import mcfsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_step      i_step,
    input  logic       i_stall,
    output logic       o_free,
    output logic       o_valid,
    output logic [3:0] o_fsm_state,
    output logic [1:0] o_pc_update,
    output logic [1:0] o_pc_source,
    output logic [3:0] o_alu_operation,
    output logic [1:0] o_alu_src_a,
    output logic [1:0] o_alu_src_b,
    output logic       o_reg_write,
    output logic [1:0] o_reg_dst,
    output logic       o_i_or_d,
    output logic [1:0] o_mem_cmd,
    output logic [1:0] o_reg_data_loc,
    output logic       o_ir_write
);

    logic       r_valid, n_valid;
    logic [3:0] r_code;
    t_alu_op    r_op;
    t_ctl       r_ctl;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= state_code(i_step.state);
            r_op   <= i_step.alu_op;
            r_ctl  <= ctl_word(i_step.state);
        end
    end

    assign o_valid         = r_valid;
    assign o_fsm_state     = r_code;
    assign o_alu_operation = r_op;
    assign o_pc_update     = r_ctl.pc_update;
    assign o_pc_source     = r_ctl.pc_source;
    assign o_alu_src_a     = r_ctl.alu_src_a;
    assign o_alu_src_b     = r_ctl.alu_src_b;
    assign o_reg_write     = r_ctl.reg_write;
    assign o_reg_dst       = r_ctl.reg_dst;
    assign o_i_or_d        = r_ctl.i_or_d;
    assign o_mem_cmd       = r_ctl.mem_cmd;
    assign o_reg_data_loc  = r_ctl.reg_data_loc;
    assign o_ir_write      = r_ctl.ir_write;

endmodule
